// ----- hw/rtl/csl_pkg.sv -----
package csl_pkg;

  // Field widths of a token beat, keyword count and queue depth.
  localparam int KIND_BITS   = 5;
  localparam int NUM_BITS    = 63;
  localparam int KW_COUNT    = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NUM, KIND_IDENT, KIND_RETURN, KIND_IF, KIND_ELSE, KIND_WHILE, KIND_FOR,
    KIND_EQ, KIND_NE, KIND_LE, KIND_GE,
    KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_LPAREN, KIND_RPAREN,
    KIND_LT, KIND_GT, KIND_SEMI, KIND_ASSIGN, KIND_LBRACE, KIND_RBRACE,
    KIND_EOF, KIND_ERROR
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_NAME, MODE_NUMBER, MODE_OPERATOR, MODE_ERROR
  } mode_e;

  typedef enum logic [1:0] {
    OP_ASSIGN, OP_LESS, OP_GREATER, OP_BANG
  } op_e;

  typedef enum logic [2:0] {
    CLS_SPACE, CLS_LETTER, CLS_DIGIT, CLS_OPER, CLS_PUNCT, CLS_OTHER
  } char_cls_e;

  // Keyword spellings, padded with zeros to eight columns.
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

  // Token kind of each keyword slot.
  function automatic tok_kind_e kw_kind(input int k);
    tok_kind_e kind;
    case (k)
      0:       kind = KIND_RETURN;
      1:       kind = KIND_IF;
      2:       kind = KIND_ELSE;
      3:       kind = KIND_WHILE;
      default: kind = KIND_FOR;
    endcase
    return kind;
  endfunction

  // Character class of one source byte; operator starts win over punctuation.
  function automatic char_cls_e classify(input logic [7:0] c);
    char_cls_e cls;
    if (c inside {8'h20, [8'h09:8'h0D]}) begin
      cls = CLS_SPACE;
    end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
      cls = CLS_LETTER;
    end else if (c inside {["0":"9"]}) begin
      cls = CLS_DIGIT;
    end else if (c inside {"=", "<", ">", "!"}) begin
      cls = CLS_OPER;
    end else if (c inside {"+", "-", "*", "/", "(", ")", ";", "{", "}"}) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // Operator code of a byte that may open a two-character operator.
  function automatic op_e op_code(input logic [7:0] c);
    op_e op;
    case (c)
      "=":     op = OP_ASSIGN;
      "<":     op = OP_LESS;
      ">":     op = OP_GREATER;
      default: op = OP_BANG;
    endcase
    return op;
  endfunction

  // Token kind of a single-character punctuation byte.
  function automatic tok_kind_e punct_kind(input logic [7:0] c);
    tok_kind_e kind;
    case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_STAR;
      "/":     kind = KIND_SLASH;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      ";":     kind = KIND_SEMI;
      "{":     kind = KIND_LBRACE;
      default: kind = KIND_RBRACE;
    endcase
    return kind;
  endfunction

endpackage

// ----- hw/rtl/csl_front.sv -----
module csl_front import csl_pkg::*; #(
  parameter int POSITION_BITS    = 16,
  parameter int NAME_LENGTH_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // text_byte
  input  logic [0:0]           s_axis_tuser,   // end_of_text
  input  logic                 queue_full_i,
  output logic                 push_o,
  output logic [1+2*KIND_BITS+NUM_BITS+2*POSITION_BITS+NAME_LENGTH_BITS-1:0] rec_o
);

  localparam int P = POSITION_BITS;
  localparam int L = NAME_LENGTH_BITS;

  // One step's tokens: slot 0 is complete, slot 1 only ever holds
  // a token with zero value and length.
  typedef struct packed {
    logic          two;
    tok_kind_e     kind1;
    logic [P-1:0]  start1;
    tok_kind_e     kind0;
    logic [NUM_BITS-1:0] value0;
    logic [P-1:0]  start0;
    logic [L-1:0]  len0;
  } rec_t;

  mode_e               mode_q, mode_d;
  op_e                 pend_q, pend_d;
  logic [P-1:0]        tok_start_q, tok_start_d;
  logic [P-1:0]        text_pos_q, text_pos_d;
  logic [L-1:0]        run_len_q, run_len_d;
  logic [KW_COUNT-1:0] flags_q, flags_d;
  logic [NUM_BITS-1:0] acc_q, acc_d;

  logic                in_fire;
  logic [7:0]          c;
  logic                eot;
  char_cls_e           cls;
  logic [KW_COUNT-1:0] flags_cont;
  logic [KW_COUNT-1:0] flags_start;
  logic [NUM_BITS+3:0] acc_sum;
  logic [NUM_BITS-1:0] acc_next;
  logic                flush_v;
  logic                flush_err;
  logic                kw_found;
  tok_kind_e           flush_kind;
  logic [NUM_BITS-1:0] flush_value;
  logic [L-1:0]        flush_len;
  rec_t                rec;

  assign s_axis_tready = !queue_full_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;
  assign eot           = s_axis_tuser[0];
  assign cls           = classify(c);

  // Keyword match flags, for a running name and for a fresh one.
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      flags_cont[k]  = flags_q[k] && (run_len_q < L'(KW_LEN[k])) &&
                       (KW_TEXT[k][run_len_q[2:0]] == c);
      flags_start[k] = (KW_TEXT[k][0] == c);
    end
  end

  // Decimal accumulate with saturation: ten times the value as two shifts.
  assign acc_sum  = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1) +
                    (NUM_BITS+4)'(c[3:0]);
  assign acc_next = (|acc_sum[NUM_BITS+3:NUM_BITS]) ? NUM_MAX : acc_sum[NUM_BITS-1:0];

  // Token that the pending run yields when it ends.
  always_comb begin
    flush_v     = 1'b0;
    flush_err   = 1'b0;
    kw_found    = 1'b0;
    flush_kind  = KIND_NUM;
    flush_value = '0;
    flush_len   = '0;
    case (mode_q)
      MODE_NAME: begin
        flush_v    = 1'b1;
        flush_kind = KIND_IDENT;
        flush_len  = run_len_q;
        for (int k = 0; k < KW_COUNT; k++) begin
          if (!kw_found && flags_q[k] && (run_len_q == L'(KW_LEN[k]))) begin
            kw_found   = 1'b1;
            flush_kind = kw_kind(k);
            flush_len  = '0;
          end
        end
      end
      MODE_NUMBER: begin
        flush_v     = 1'b1;
        flush_kind  = KIND_NUM;
        flush_value = acc_q;
      end
      MODE_OPERATOR: begin
        flush_v = 1'b1;
        case (pend_q)
          OP_ASSIGN:  flush_kind = KIND_ASSIGN;
          OP_LESS:    flush_kind = KIND_LT;
          OP_GREATER: flush_kind = KIND_GT;
          default: begin
            flush_kind = KIND_ERROR;
            flush_err  = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Lexer next state and the tokens of this beat.
  always_comb begin
    mode_d      = mode_q;
    pend_d      = pend_q;
    tok_start_d = tok_start_q;
    text_pos_d  = text_pos_q;
    run_len_d   = run_len_q;
    flags_d     = flags_q;
    acc_d       = acc_q;
    push_o      = 1'b0;
    rec.two     = 1'b0;
    rec.kind1   = KIND_EOF;
    rec.start1  = text_pos_q;
    rec.kind0   = flush_kind;
    rec.value0  = flush_value;
    rec.start0  = tok_start_q;
    rec.len0    = flush_len;

    if (in_fire) begin
      if (eot) begin
        // End of text: pending token, then EOF at the current offset.
        push_o = 1'b1;
        if (flush_v) begin
          rec.two = 1'b1;
        end else begin
          rec.kind0  = KIND_EOF;
          rec.value0 = '0;
          rec.start0 = text_pos_q;
          rec.len0   = '0;
        end
        mode_d     = MODE_IDLE;
        pend_d     = OP_ASSIGN;
        text_pos_d = '0;
        run_len_d  = '0;
        flags_d    = '1;
        acc_d      = '0;
      end else begin
        text_pos_d = text_pos_q + P'(1);
        if (mode_q == MODE_NAME && (cls == CLS_LETTER || cls == CLS_DIGIT)) begin
          flags_d = flags_cont;
          if (run_len_q != '1) begin
            run_len_d = run_len_q + L'(1);
          end
        end else if (mode_q == MODE_NUMBER && cls == CLS_DIGIT) begin
          acc_d = acc_next;
        end else if (mode_q == MODE_OPERATOR && c == "=") begin
          // Two-character operator completes.
          push_o     = 1'b1;
          rec.value0 = '0;
          rec.len0   = '0;
          case (pend_q)
            OP_ASSIGN:  rec.kind0 = KIND_EQ;
            OP_LESS:    rec.kind0 = KIND_LE;
            OP_GREATER: rec.kind0 = KIND_GE;
            default:    rec.kind0 = KIND_NE;
          endcase
          mode_d = MODE_IDLE;
        end else if (mode_q != MODE_ERROR) begin
          // The byte ends the pending run and starts something new.
          push_o = flush_v;
          mode_d = flush_err ? MODE_ERROR : MODE_IDLE;
          if (!flush_err) begin
            tok_start_d = text_pos_q;
            case (cls)
              CLS_SPACE: ;
              CLS_LETTER: begin
                mode_d    = MODE_NAME;
                flags_d   = flags_start;
                run_len_d = L'(1);
              end
              CLS_DIGIT: begin
                mode_d = MODE_NUMBER;
                acc_d  = NUM_BITS'(c[3:0]);
              end
              CLS_OPER: begin
                mode_d = MODE_OPERATOR;
                pend_d = op_code(c);
              end
              default: begin
                // Punctuation or an unknown byte gives a token right away.
                if (cls == CLS_OTHER) begin
                  mode_d = MODE_ERROR;
                end
                if (flush_v) begin
                  rec.two   = 1'b1;
                  rec.kind1 = (cls == CLS_PUNCT) ? punct_kind(c) : KIND_ERROR;
                end else begin
                  push_o     = 1'b1;
                  rec.kind0  = (cls == CLS_PUNCT) ? punct_kind(c) : KIND_ERROR;
                  rec.value0 = '0;
                  rec.start0 = text_pos_q;
                  rec.len0   = '0;
                end
              end
            endcase
          end
        end
      end
    end
  end

  assign rec_o = rec;

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pend_q      <= OP_ASSIGN;
      tok_start_q <= '0;
      text_pos_q  <= '0;
      run_len_q   <= '0;
      flags_q     <= '1;
      acc_q       <= '0;
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      tok_start_q <= tok_start_d;
      text_pos_q  <= text_pos_d;
      run_len_q   <= run_len_d;
      flags_q     <= flags_d;
      acc_q       <= acc_d;
    end
  end

endmodule

// ----- hw/rtl/csl_queue.sv -----
module csl_queue import csl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/csl_back.sv -----
module csl_back import csl_pkg::*; #(
  parameter int POSITION_BITS    = 16,
  parameter int NAME_LENGTH_BITS = 8,
  parameter int SERIAL_BITS      = 16,
  localparam int OutW   = KIND_BITS + NUM_BITS + POSITION_BITS + NAME_LENGTH_BITS +
                          SERIAL_BITS,
  localparam int TdataW = ((OutW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  logic [1+2*KIND_BITS+NUM_BITS+2*POSITION_BITS+NAME_LENGTH_BITS-1:0] rec_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // token_kind, number_value, start_position, name_length, keyword_serial
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int P = POSITION_BITS;
  localparam int L = NAME_LENGTH_BITS;
  localparam int S = SERIAL_BITS;

  typedef struct packed {
    logic          two;
    tok_kind_e     kind1;
    logic [P-1:0]  start1;
    tok_kind_e     kind0;
    logic [NUM_BITS-1:0] value0;
    logic [P-1:0]  start0;
    logic [L-1:0]  len0;
  } rec_t;

  rec_t                rec;
  logic                load;
  logic                phase_q;
  logic                valid_q;
  tok_kind_e           kind_q, sel_kind;
  logic [NUM_BITS-1:0] value_q, sel_value;
  logic [P-1:0]        start_q, sel_start;
  logic [L-1:0]        len_q, sel_len;
  logic [S-1:0]        serial_q, sel_serial;
  logic                last_q, sel_last;
  logic [S-1:0]        if_cnt_q, while_cnt_q, for_cnt_q;

  assign rec   = rec_i;
  assign load  = fifo_valid_i && (!valid_q || m_axis_tready);
  assign pop_o = load && (phase_q || !rec.two);

  // Pick the next token of the head entry and its keyword serial.
  always_comb begin
    if (phase_q) begin
      sel_kind  = rec.kind1;
      sel_value = '0;
      sel_start = rec.start1;
      sel_len   = '0;
      sel_last  = 1'b1;
    end else begin
      sel_kind  = rec.kind0;
      sel_value = rec.value0;
      sel_start = rec.start0;
      sel_len   = rec.len0;
      sel_last  = !rec.two;
    end
    case (sel_kind)
      KIND_IF:    sel_serial = if_cnt_q;
      KIND_WHILE: sel_serial = while_cnt_q;
      KIND_FOR:   sel_serial = for_cnt_q;
      default:    sel_serial = '0;
    endcase
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= sel_kind;
      value_q  <= sel_value;
      start_q  <= sel_start;
      len_q    <= sel_len;
      serial_q <= sel_serial;
      last_q   <= sel_last;
    end
  end

  // Beat valid, entry phase and keyword counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      phase_q     <= 1'b0;
      if_cnt_q    <= '0;
      while_cnt_q <= '0;
      for_cnt_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= !phase_q && rec.two;
        if (sel_kind == KIND_IF) begin
          if_cnt_q <= if_cnt_q + S'(1);
        end
        if (sel_kind == KIND_WHILE) begin
          while_cnt_q <= while_cnt_q + S'(1);
        end
        if (sel_kind == KIND_FOR) begin
          for_cnt_q <= for_cnt_q + S'(1);
        end
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = TdataW'({serial_q, len_q, start_q, value_q, kind_q});

  // The second token of an entry is only pending while that entry is held.
  a_phase_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> fifo_valid_i) else $error("second token pending with empty queue");

  // A beat that is not the last of its step leaves the second token pending.
  a_not_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |-> phase_q) else $error("non-final beat without follower");

  // Serials appear only on counted keywords.
  a_serial_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && serial_q != '0) |->
      (kind_q == KIND_IF || kind_q == KIND_WHILE || kind_q == KIND_FOR))
    else $error("keyword serial on wrong token kind");

  // The queue is never popped empty.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> fifo_valid_i) else $error("pop from empty queue");

endmodule

// ----- hw/rtl/c_subset_lexer_top.sv -----
// Byte-serial lexer: one source byte (or end-of-text beat) accepted per cycle while
// the queue is not full. The first token of a byte is registered in the queue and
// then in the output register.
// Throughput: one token beat per cycle unless the sink stalls; a byte with two tokens
// gives two beats, absorbed by a four-entry queue between lexer and output stage.
// Reset: asynchronous active low; lexer idles at offset zero, keyword serials clear.
module c_subset_lexer_top import csl_pkg::*; #(
  parameter int POSITION_BITS    = 16,
  parameter int NAME_LENGTH_BITS = 8,
  parameter int SERIAL_BITS      = 16,
  localparam int OutW   = KIND_BITS + NUM_BITS + POSITION_BITS + NAME_LENGTH_BITS +
                          SERIAL_BITS,
  localparam int TdataW = ((OutW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // text_byte
  input  logic [0:0]        s_axis_tuser,   // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // token_kind, number_value, start_position, name_length, keyword_serial
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int RecW = 1 + 2 * KIND_BITS + NUM_BITS + 2 * POSITION_BITS +
                        NAME_LENGTH_BITS;

  logic            push;
  logic            pop;
  logic            queue_full;
  logic            queue_valid;
  logic [RecW-1:0] rec_in;
  logic [RecW-1:0] rec_out;

  // Lexer front end.
  csl_front #(
    .POSITION_BITS   (POSITION_BITS),
    .NAME_LENGTH_BITS(NAME_LENGTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .queue_full_i (queue_full),
    .push_o       (push),
    .rec_o        (rec_in)
  );

  // Step queue.
  csl_queue #(
    .WIDTH(RecW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec_in),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .data_o (rec_out),
    .full_o (queue_full)
  );

  // Token output stage.
  csl_back #(
    .POSITION_BITS   (POSITION_BITS),
    .NAME_LENGTH_BITS(NAME_LENGTH_BITS),
    .SERIAL_BITS     (SERIAL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (queue_valid),
    .rec_i        (rec_out),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
